@@ sv/rational_arith_unit_macros.svh @@
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define RAU_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("rational_arith_unit check failed");

// Condition holds in the cycle after the trigger.
`define RAU_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("rational_arith_unit check failed");

`endif

@@ sv/rau_pkg.sv @@
`default_nettype none
package rau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               status;
  } out_t;

  typedef struct packed {
    logic        go;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [63:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ sv/rational_arith_unit.sv @@
// Sequence: setup and cross products, then Euclid steps (at most about 93 steps on 64-bit
// values), then the two final divisions; a zero denominator ends it after the setup.
// Throughput: one word at a time; busy stays high from acceptance until the result strobe.
// All work runs through one 33x33 multiplier and one radix-2 64-bit divider.
// Reset is synchronous and returns the sequencer to idle; the receiver cannot stall results.
`default_nettype none
`include "rational_arith_unit_macros.svh"
module rational_arith_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire rau_pkg::in_t operands,
  output logic              done,
  output rau_pkg::out_t     result
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_M3   = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_GCD  = 4'd6;
  localparam logic [3:0] ST_GW   = 4'd7;
  localparam logic [3:0] ST_QN   = 4'd8;
  localparam logic [3:0] ST_QNW  = 4'd9;
  localparam logic [3:0] ST_QD   = 4'd10;
  localparam logic [3:0] ST_QDW  = 4'd11;

  logic [3:0]          state;
  rau_pkg::in_t        opd;
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  prod;
  logic signed [64:0]  p1;
  logic signed [64:0]  num;
  logic signed [63:0]  den;
  logic [63:0]         nmag;
  logic [63:0]         dmag;
  logic                neg;
  logic [63:0]         x;
  logic [63:0]         y;
  logic [63:0]         nq;
  rau_pkg::div_req_t   div_req;
  rau_pkg::div_rsp_t   div_rsp;

  assign busy = (state != ST_IDLE);

  always_comb begin
    mul_a = {opd.a_num[31], opd.a_num};
    mul_b = $signed({2'b00, opd.a_den});
    unique case (state)
      ST_M0: begin
        mul_a = {opd.a_num[31], opd.a_num};
        mul_b = (opd.operation == rau_pkg::OP_MUL) ? {opd.b_num[31], opd.b_num}
                                                   : $signed({2'b00, opd.b_den});
      end
      ST_M1: begin
        mul_a = {opd.b_num[31], opd.b_num};
        mul_b = $signed({2'b00, opd.a_den});
      end
      ST_M2: begin
        mul_a = $signed({2'b00, opd.a_den});
        mul_b = (opd.operation == rau_pkg::OP_DIV) ? {opd.b_num[31], opd.b_num}
                                                   : $signed({2'b00, opd.b_den});
      end
      default: begin
      end
    endcase
  end

  rau_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    div_req.go       = 1'b0;
    div_req.dividend = x;
    div_req.divisor  = y;
    unique case (state)
      ST_GCD: div_req.go = (y != 64'd0);
      ST_QN: begin
        div_req.go       = 1'b1;
        div_req.dividend = nmag;
        div_req.divisor  = x;
      end
      ST_QD: begin
        div_req.go       = 1'b1;
        div_req.dividend = dmag;
        div_req.divisor  = x;
      end
      default: begin
      end
    endcase
  end

  rau_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: if (start) state <= ST_M0;
        ST_M0:   state <= ST_M1;
        ST_M1:   state <= ST_M2;
        ST_M2:   state <= ST_M3;
        ST_M3:   state <= ST_CHK;
        ST_CHK: begin
          if (den == 64'sd0) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_GCD;
          end
        end
        ST_GCD:  state <= (y == 64'd0) ? ST_QN : ST_GW;
        ST_GW:   if (div_rsp.done) state <= ST_GCD;
        ST_QN:   state <= ST_QNW;
        ST_QNW:  if (div_rsp.done) state <= ST_QD;
        ST_QD:   state <= ST_QDW;
        ST_QDW: begin
          if (div_rsp.done) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (start) opd <= operands;
      ST_M1:   p1 <= 65'(prod);
      ST_M2: begin
        unique case (opd.operation)
          rau_pkg::OP_ADD: num <= p1 + 65'(prod);
          rau_pkg::OP_SUB: num <= p1 - 65'(prod);
          default:         num <= p1;
        endcase
      end
      ST_M3:   den <= prod[63:0];
      ST_CHK: begin
        neg  <= num[64] ^ den[63];
        nmag <= num[64] ? 64'(-num) : num[63:0];
        dmag <= den[63] ? 64'(-den) : den[63:0];
        x    <= num[64] ? 64'(-num) : num[63:0];
        y    <= den[63] ? 64'(-den) : den[63:0];
        result <= '{res_num: 64'sd0, res_den: 63'd0, status: 1'b1};
      end
      ST_GW: begin
        if (div_rsp.done) begin
          x <= y;
          y <= div_rsp.remainder;
        end
      end
      ST_QNW:  if (div_rsp.done) nq <= div_rsp.quotient;
      ST_QDW: begin
        if (div_rsp.done) begin
          result.status <= 1'b0;
          if (nq == 64'd0) begin
            result.res_num <= 64'sd0;
            result.res_den <= 63'd1;
          end else begin
            result.res_num <= neg ? $signed(64'(-nq)) : $signed(nq);
            result.res_den <= div_rsp.quotient[62:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  `RAU_ASSERT_SAME(a_done_busy, done, $past(busy))
  `RAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RAU_ASSERT_NEXT(a_single_done, done, !done)
  `RAU_ASSERT_SAME(a_ok_den, done && !result.status, result.res_den != 63'd0)

endmodule
`default_nettype wire

@@ sv/rau_mul.sv @@
`default_nettype none
module rau_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

@@ sv/rau_div.sv @@
`default_nettype none
module rau_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t      rsp
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [5:0]  cnt;
  logic        run;
  logic        done;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  assign rem_sh = {rem, quo[63]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
      end else if (run && cnt == 6'd63) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 6'd1;
      if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

@@ test/tb_rational_arith_unit.sv @@
`timescale 1ns / 100ps
module tb_rational_arith_unit;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rau_pkg::in_t operands = '0;
  logic done;
  rau_pkg::out_t result;

  always #6 clk = ~clk;

  rational_arith_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operands(operands), .done(done), .result(result)
  );

  class fraction_board;
    rau_pkg::out_t pending_fracs[$];
    int mismatches = 0;
    int matched = 0;

    function rau_pkg::out_t reduce_fraction(rau_pkg::in_t w);
      logic signed [63:0] an, ad, bn, bd, num, den;
      logic [63:0] nmag, dmag, x, y, r;
      logic neg;
      rau_pkg::out_t o;
      an = 64'(w.a_num);
      bn = 64'(w.b_num);
      ad = {33'd0, w.a_den};
      bd = {33'd0, w.b_den};
      case (w.operation)
        rau_pkg::OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
        rau_pkg::OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
        rau_pkg::OP_MUL: begin num = an * bn; den = ad * bd; end
        default: begin num = an * bd; den = ad * bn; end
      endcase
      if (den == 0) begin
        o.res_num = '0;
        o.res_den = '0;
        o.status = 1'b1;
        return o;
      end
      neg = (num < 0) != (den < 0);
      nmag = (num < 0) ? -num : num;
      dmag = (den < 0) ? -den : den;
      x = nmag;
      y = dmag;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      nmag = nmag / x;
      dmag = dmag / x;
      if (nmag == 0) begin
        dmag = 64'd1;
        neg = 1'b0;
      end
      o.res_num = neg ? -nmag : nmag;
      o.res_den = dmag[62:0];
      o.status = 1'b0;
      return o;
    endfunction

    function void note_word(rau_pkg::in_t w);
      pending_fracs.push_back(reduce_fraction(w));
    endfunction

    function void check_word(rau_pkg::out_t got);
      rau_pkg::out_t want;
      if (pending_fracs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", got);
        return;
      end
      want = pending_fracs.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %0d/%0d st %0b, got %0d/%0d st %0b",
                   want.res_num, want.res_den, want.status,
                   got.res_num, got.res_den, got.status);
      end else begin
        matched++;
      end
    endfunction
  endclass

  fraction_board board = new();
  int idle_cycles = 0;
  int sent = 0;
  localparam int WATCHDOG = 40000;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_word(operands);
      if (done) board.check_word(result);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Watchdog expired with no progress.");
        $display("tb_rational_arith_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(rau_pkg::in_t w);
    operands <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    sent++;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'(int'($urandom_range(0, 20)) - 10);
      3: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 5))
      0: return 31'd1;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(1, 30));
      3: return 31'($urandom_range(1, 5000));
      default: return 31'($urandom_range(1, 32'h7fff_ffff));
    endcase
  endfunction

  function automatic rau_pkg::in_t make_word(logic [1:0] op, logic signed [31:0] an,
                                             logic [30:0] ad, logic signed [31:0] bn,
                                             logic [30:0] bd);
    rau_pkg::in_t w;
    w.operation = op;
    w.a_num = an;
    w.a_den = ad;
    w.b_num = bn;
    w.b_den = bd;
    return w;
  endfunction

  initial begin
    rau_pkg::in_t w;
    int gap;
    int burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int op = 0; op < 4; op++) begin
      send_word(make_word(2'(op), 32'sd3, 31'd4, 32'sd5, 31'd6));
      send_word(make_word(2'(op), 32'sh8000_0000, 31'h7fff_ffff, 32'sh8000_0000,
                          31'h7fff_ffff));
      send_word(make_word(2'(op), 32'sh7fff_ffff, 31'd1, 32'sh7fff_ffff, 31'd1));
      send_word(make_word(2'(op), 32'sh8000_0000, 31'd1, 32'sh7fff_ffff, 31'h7fff_ffff));
      send_word(make_word(2'(op), 32'sd0, 31'd7, 32'sd0, 31'd9));
    end
    send_word(make_word(rau_pkg::OP_SUB, 32'sd5, 31'd3, 32'sd5, 31'd3));
    send_word(make_word(rau_pkg::OP_ADD, -32'sd2, 31'd4, 32'sd1, 31'd2));
    send_word(make_word(rau_pkg::OP_DIV, 32'sd7, 31'd2, -32'sd3, 31'd5));
    send_word(make_word(rau_pkg::OP_DIV, -32'sd7, 31'd2, 32'sd0, 31'd5));
    while (sent < 600) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        w.operation = 2'($urandom_range(0, 3));
        w.a_num = rand_num();
        w.a_den = rand_den();
        w.b_num = rand_num();
        w.b_den = rand_den();
        if (w.operation == rau_pkg::OP_DIV && $urandom_range(0, 15) == 0) w.b_num = '0;
        send_word(w);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      repeat (gap) @(posedge clk);
    end
    while (board.pending_fracs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d words over all four operations, including extremes and zero cases;",
             sent);
    $display("%0d results matched, %0d mismatched.", board.matched, board.mismatches);
    if (board.mismatches == 0 && board.pending_fracs.size() == 0) begin
      $display("tb_rational_arith_unit: PASS");
    end else begin
      $display("tb_rational_arith_unit: FAIL");
    end
    $finish;
  end
endmodule

@@ rational_arith_unit.f @@
+incdir+sv
sv/rau_pkg.sv
sv/rau_mul.sv
sv/rau_div.sv
sv/rational_arith_unit.sv
test/tb_rational_arith_unit.sv
